// ===== design/sky_dome_radiance_lookup_defines.svh =====
// assertion macros for the sky dome radiance lookup
// needs clk and rst in the scope of each use
`ifndef SKY_DOME_RADIANCE_LOOKUP_DEFINES_SVH
`define SKY_DOME_RADIANCE_LOOKUP_DEFINES_SVH

// same-cycle implication
`define SDRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdrl assertion failed");

// next-cycle implication
`define SDRL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdrl assertion failed");

`endif

// ===== design/sdrl_pkg.sv =====
// shared types, constants and the gamma table of the sky dome lookup
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdrl_pkg;

  localparam int CW         = 38;   // cordic coordinate width
  localparam int ACCW       = 34;   // cordic angle accumulator width
  localparam int GAMMA_X100 = 220;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [30:0] QUARTER_TURN = 31'h4000_0000;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  // configuration register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_RED    = 3'd1;
  localparam logic [2:0] REG_GREEN  = 3'd2;
  localparam logic [2:0] REG_BLUE   = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [CW-1:0]   a;
    logic signed [CW-1:0]   b;
    logic signed [ACCW-1:0] acc;
  } cordic_t;

  typedef logic [15:0] gamma_tab_t [256];

  // integer square root, elaboration only
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] vv;
    res   = '0;
    bit_v = 64'h1 << 62;
    vv    = v;
    while (bit_v > vv) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (vv >= res + bit_v) begin
        vv  = vv - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // log2 in q16, elaboration only
  function automatic logic [63:0] log2_q16(int unsigned b);
    int unsigned p;
    logic [63:0] m;
    logic [63:0] frac;
    p    = 0;
    frac = '0;
    while ((b >> (p + 1)) != 0) p++;
    m = 64'(b) << (30 - p);
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'h1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'h1 << (16 - i));
      end
    end
    return (64'(p) << 16) | frac;
  endfunction

  // byte to 16-bit linear table
  function automatic gamma_tab_t build_gamma();
    gamma_tab_t  tab;
    logic [63:0] roots [16];
    logic [63:0] cur;
    logic [63:0] full;
    logic [63:0] e;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] v;
    cur  = 64'h1 << 29;
    full = log2_q16(255);
    for (int k = 0; k < 16; k++) begin
      cur = isqrt64(cur << 30);
      roots[k] = cur;
    end
    tab[0] = '0;
    for (int b = 1; b < 256; b++) begin
      e = ((full - log2_q16(b)) * 64'(GAMMA_X100)) / 100;
      n = e >> 16;
      f = e & 64'hFFFF;
      r = 64'h1 << 30;
      for (int k = 1; k <= 16; k++)
        if (f[16-k]) r = (r * roots[k-1]) >> 30;
      if (n > 32) v = '0;
      else v = (r * 64'd65535 + (64'h1 << (29 + n))) >> (30 + n);
      tab[b] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_ROM = build_gamma();

endpackage

`default_nettype wire

// ===== design/sdrl_ram.sv =====
// generic single write, single read ram with registered read (read-first)
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sdrl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/sdrl_cordic_cell.sv =====
// one vectoring cordic cell: a fixed shift, add/sub and angle update
// depends on sdrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdrl_cordic_cell import sdrl_pkg::*; #(
  parameter int STEP = 0,
  parameter int TW   = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_vld,
  input  wire cordic_t       in_d,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_vld,
  output cordic_t            out_d,
  output logic      [TW-1:0] out_tag
);

  localparam logic signed [ACCW-1:0] ATAN_STEP = ACCW'(ATAN_TAB[STEP]);

  cordic_t d_next;

  // rotate toward the a axis
  always_comb begin
    if (!in_d.b[CW-1]) begin
      d_next.a   = in_d.a + (in_d.b >>> STEP);
      d_next.b   = in_d.b - (in_d.a >>> STEP);
      d_next.acc = in_d.acc + ATAN_STEP;
    end else begin
      d_next.a   = in_d.a - (in_d.b >>> STEP);
      d_next.b   = in_d.b + (in_d.a >>> STEP);
      d_next.acc = in_d.acc - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_d   <= d_next;
    out_tag <= in_tag;
  end

endmodule

`default_nettype wire

// ===== design/sky_dome_radiance_lookup.sv =====
// top level of the sky dome radiance lookup: two cordic cell chains,
// index math, texel ram and gamma table; depends on sdrl_pkg, sdrl_cordic_cell, sdrl_ram
//
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// item in  | start, busy        | action, texel_index, texel_*, dir_x/y/z
// config   | cfg_write          | cfg_index, cfg_data
// result   | done (one cycle)   | radiance_red, radiance_green, radiance_blue
//
// one beat is taken every cycle; busy is high only during reset
// a query result passes the input register, the two cordic cell chains, the split gain
// multiply, the row, column and address registers and the ram read
// a load is delayed through ld_pipe before it writes the ram, in step with queries
// no clearing pass after reset; the result side cannot stall
`timescale 1ns / 1ps
`default_nettype none

`include "sky_dome_radiance_lookup_defines.svh"

module sky_dome_radiance_lookup import sdrl_pkg::*; #(
  parameter int MAX_TEXELS   = 262144,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [17:0] texel_index,
  input  wire logic [7:0]  texel_blue,
  input  wire logic [7:0]  texel_green,
  input  wire logic [7:0]  texel_red,
  input  wire logic [15:0] dir_x,
  input  wire logic [15:0] dir_y,
  input  wire logic [15:0] dir_z,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             done,
  output logic [15:0]      radiance_red,
  output logic [15:0]      radiance_green,
  output logic [15:0]      radiance_blue
);

  localparam int N   = CORDIC_STEPS;
  localparam int AW  = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
  localparam int LD  = 2 * N + 6;
  localparam int LAT = 2 * N + 8;
  localparam int T1W = 19;
  localparam int T2W = 33;
  localparam int SPL = 19;

  typedef struct packed {
    logic          vld;
    logic [AW-1:0] addr;
    logic [23:0]   data;
  } load_t;

  // configuration registers
  logic        mode;
  logic [15:0] solid_red, solid_green, solid_blue;
  logic [12:0] image_width, image_height;
  logic [12:0] w_eff, h_eff;

  // stage signals
  logic             accept;
  logic             p1_vld [N+1];
  cordic_t          p1_d   [N+1];
  logic [T1W-1:0]   p1_tag [N+1];
  logic             p2_vld [N+1];
  cordic_t          p2_d   [N+1];
  logic [T2W-1:0]   p2_tag [N+1];
  load_t            ld_pipe [LD];

  logic signed [CW-1:0] z_ext, x_ext;
  logic                 z_neg;

  logic [31:0]          az_fin;
  logic                 g1_vld, g1_black;
  logic [31:0]          g1_az;
  logic [15:0]          g1_y;
  logic [SPL+29:0]      g1_lo, g1_hi;
  logic [SPL+SPL+29:0]  g_sum;

  logic [30:0]          polar;
  logic                 r1_vld, r1_black;
  logic [44:0]          r1_colp;
  logic [43:0]          r1_rowp;
  logic                 r2_vld, r2_black;
  logic [12:0]          r2_row, r2_col;
  logic [13:0]          row_t;
  logic [26:0]          idx;
  logic                 r3_vld, r3_black;
  logic [AW-1:0]        r3_addr;
  logic                 r4_vld, r4_black;
  logic [23:0]          rd_data;

  assign busy   = rst;
  assign accept = start && !busy;
  assign w_eff  = (image_width  == '0) ? 13'd1 : image_width;
  assign h_eff  = (image_height == '0) ? 13'd1 : image_height;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      solid_red    <= '0;
      solid_green  <= '0;
      solid_blue   <= '0;
      image_width  <= 13'd1;
      image_height <= 13'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:   mode         <= cfg_data[0];
        REG_RED:    solid_red    <= cfg_data;
        REG_GREEN:  solid_green  <= cfg_data;
        REG_BLUE:   solid_blue   <= cfg_data;
        REG_WIDTH:  image_width  <= cfg_data[12:0];
        REG_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // input stage: fold negative z by a half turn
  assign z_ext = CW'($signed(dir_z)) <<< 16;
  assign x_ext = CW'($signed(dir_x)) <<< 16;
  assign z_neg = dir_z[15];

  always_ff @(posedge clk) begin
    if (rst) p1_vld[0] <= 1'b0;
    else     p1_vld[0] <= accept && action;
  end

  always_ff @(posedge clk) begin
    p1_d[0].a   <= z_neg ? -z_ext : z_ext;
    p1_d[0].b   <= z_neg ? -x_ext : x_ext;
    p1_d[0].acc <= '0;
    p1_tag[0]   <= {dir_y, (dir_x == '0) && (dir_z == '0), z_neg, dir_y[15]};
  end

  // azimuth chain
  for (genvar i = 0; i < N; i++) begin : g_az
    sdrl_cordic_cell #(.STEP(i), .TW(T1W)) u_cell (
      .clk(clk), .rst(rst),
      .in_vld(p1_vld[i]), .in_d(p1_d[i]), .in_tag(p1_tag[i]),
      .out_vld(p1_vld[i+1]), .out_d(p1_d[i+1]), .out_tag(p1_tag[i+1])
    );
  end

  // azimuth with half-turn offset when z is not negative; a half turn when x and z are zero
  always_comb begin
    if (p1_tag[N][2])      az_fin = HALF_TURN;
    else if (p1_tag[N][1]) az_fin = p1_d[N].acc[31:0];
    else                   az_fin = p1_d[N].acc[31:0] + HALF_TURN;
  end

  // gain correction, split into two partial products
  always_ff @(posedge clk) begin
    if (rst) g1_vld <= 1'b0;
    else     g1_vld <= p1_vld[N];
  end

  always_ff @(posedge clk) begin
    g1_lo    <= 49'(p1_d[N].a[SPL-1:0]) * 49'(INV_GAIN_Q30);
    g1_hi    <= 49'(p1_d[N].a[CW-1:SPL]) * 49'(INV_GAIN_Q30);
    g1_az    <= az_fin;
    g1_y     <= p1_tag[N][T1W-1:3];
    g1_black <= p1_tag[N][0];
  end

  assign g_sum = ({19'd0, g1_hi} << SPL) + {19'd0, g1_lo};

  always_ff @(posedge clk) begin
    if (rst) p2_vld[0] <= 1'b0;
    else     p2_vld[0] <= g1_vld;
  end

  always_ff @(posedge clk) begin
    p2_d[0].a   <= CW'($signed(g1_y)) <<< 16;
    p2_d[0].b   <= g_sum[CW+29:30];
    p2_d[0].acc <= '0;
    p2_tag[0]   <= {g1_az, g1_black};
  end

  // polar chain
  for (genvar i = 0; i < N; i++) begin : g_pol
    sdrl_cordic_cell #(.STEP(i), .TW(T2W)) u_cell (
      .clk(clk), .rst(rst),
      .in_vld(p2_vld[i]), .in_d(p2_d[i]), .in_tag(p2_tag[i]),
      .out_vld(p2_vld[i+1]), .out_d(p2_d[i+1]), .out_tag(p2_tag[i+1])
    );
  end

  // polar clamp to a quarter turn
  always_comb begin
    if (p2_d[N].acc[ACCW-1])                                 polar = '0;
    else if (p2_d[N].acc > ACCW'(QUARTER_TURN))              polar = QUARTER_TURN;
    else                                                      polar = p2_d[N].acc[30:0];
  end

  // row and column products
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_vld <= 1'b0;
      r2_vld <= 1'b0;
      r3_vld <= 1'b0;
      r4_vld <= 1'b0;
    end else begin
      r1_vld <= p2_vld[N];
      r2_vld <= r1_vld;
      r3_vld <= r2_vld;
      r4_vld <= r3_vld;
    end
  end

  always_ff @(posedge clk) begin
    r1_colp  <= 45'(w_eff) * 45'(p2_tag[N][T2W-1:1]);
    r1_rowp  <= 44'(h_eff) * 44'(polar);
    r1_black <= p2_tag[N][0];
  end

  // clamp row to the last line
  assign row_t = r1_rowp[43:30];

  always_ff @(posedge clk) begin
    r2_col   <= r1_colp[44:32];
    r2_row   <= (row_t > 14'(h_eff - 13'd1)) ? (h_eff - 13'd1) : row_t[12:0];
    r2_black <= r1_black;
  end

  // linear texel address
  assign idx = 27'(r2_row) * 27'(w_eff) + 27'(r2_col);

  always_ff @(posedge clk) begin
    r3_addr  <= idx[AW-1:0];
    r3_black <= r2_black || (32'(idx) >= 32'(MAX_TEXELS));
    r4_black <= r3_black;
  end

  // load beats delayed to line up with query reads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LD; i++) ld_pipe[i].vld <= 1'b0;
    end else begin
      ld_pipe[0].vld <= accept && !action && (32'(texel_index) < 32'(MAX_TEXELS));
      for (int i = 1; i < LD; i++) ld_pipe[i].vld <= ld_pipe[i-1].vld;
    end
    ld_pipe[0].addr <= AW'(texel_index);
    ld_pipe[0].data <= {texel_red, texel_green, texel_blue};
    for (int i = 1; i < LD; i++) begin
      ld_pipe[i].addr <= ld_pipe[i-1].addr;
      ld_pipe[i].data <= ld_pipe[i-1].data;
    end
  end

  sdrl_ram #(.WIDTH(24), .DEPTH(MAX_TEXELS), .AW(AW)) u_store (
    .clk(clk),
    .we(ld_pipe[LD-1].vld), .waddr(ld_pipe[LD-1].addr), .wdata(ld_pipe[LD-1].data),
    .raddr(r3_addr), .rdata(rd_data)
  );

  // result register: solid colour, black, or gamma lookup of the texel
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= r4_vld;
  end

  always_ff @(posedge clk) begin
    if (!mode) begin
      radiance_red   <= solid_red;
      radiance_green <= solid_green;
      radiance_blue  <= solid_blue;
    end else if (r4_black) begin
      radiance_red   <= '0;
      radiance_green <= '0;
      radiance_blue  <= '0;
    end else begin
      radiance_red   <= GAMMA_ROM[rd_data[23:16]];
      radiance_green <= GAMMA_ROM[rd_data[15:8]];
      radiance_blue  <= GAMMA_ROM[rd_data[7:0]];
    end
  end

  // checks
  `SDRL_ASSERT_IMP(a_done_from_query, done, $past(accept && action, LAT))
  `SDRL_ASSERT_IMP(a_write_or_read, 1'b1, $onehot0({ld_pipe[LD-1].vld, r3_vld}))
  `SDRL_ASSERT_NXT(a_solid_color, r4_vld && !mode, radiance_red == $past(solid_red))

endmodule

`default_nettype wire
